// File: hdl/mf3_pkg.sv
// Shared types, constants and compare-exchange functions for the 3x3 RGB median filter.
// No dependencies; every other file imports this package.
`default_nettype none

package mf3_pkg;

   localparam int CHAN_W      = 8;
   localparam int FW_W        = 11;
   localparam int FH_W        = 12;
   localparam int CNT_W       = 13;
   localparam int CCOL_W      = 10;
   localparam int CROW_W      = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int MIN_DIM     = 3;
   localparam int RSPQ_DEPTH  = 8;
   localparam int RSPQ_AW     = 3;
   localparam int QC_W        = RSPQ_AW + 1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [FW_W-1:0] FW_RESET = 11'd640;
   localparam logic [FH_W-1:0] FH_RESET = 12'd480;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type r;
      chan_type g;
      chan_type b;
   } pix_type;

   typedef struct packed {
      chan_type hi;
      chan_type mi;
      chan_type lo;
   } tri_type;

   typedef struct packed {
      tri_type r;
      tri_type g;
      tri_type b;
   } col_type;

   typedef struct packed {
      pix_type mid;
      pix_type top;
   } line_type;

   typedef struct packed {
      logic [CCOL_W-1:0] centre_col;
      logic [CROW_W-1:0] centre_row;
      logic              frame_end;
   } meta_type;

   typedef struct packed {
      pix_type  med;
      meta_type meta;
   } rsp_type;

   function automatic tri_type sort3(chan_type a, chan_type b, chan_type c);
      tri_type  t;
      chan_type x;
      chan_type y;
      chan_type z;
      chan_type s;
      x = a;
      y = b;
      z = c;
      if (x > y) begin
         s = x; x = y; y = s;
      end
      if (y > z) begin
         s = y; y = z; z = s;
      end
      if (x > y) begin
         s = x; x = y; y = s;
      end
      t.lo = x;
      t.mi = y;
      t.hi = z;
      return t;
   endfunction

   function automatic col_type sort_col(pix_type a, pix_type b, pix_type c);
      col_type k;
      k.r = sort3(a.r, b.r, c.r);
      k.g = sort3(a.g, b.g, c.g);
      k.b = sort3(a.b, b.b, c.b);
      return k;
   endfunction

   // max of lows, median of mids, min of highs over three sorted columns
   function automatic tri_type reduce3(tri_type a, tri_type b, tri_type c);
      tri_type p;
      tri_type s_lo;
      tri_type s_mi;
      tri_type s_hi;
      s_lo = sort3(a.lo, b.lo, c.lo);
      s_mi = sort3(a.mi, b.mi, c.mi);
      s_hi = sort3(a.hi, b.hi, c.hi);
      p.lo = s_lo.hi;
      p.mi = s_mi.mi;
      p.hi = s_hi.lo;
      return p;
   endfunction

   function automatic chan_type med3(tri_type p);
      tri_type s;
      s = sort3(p.lo, p.mi, p.hi);
      return s.mi;
   endfunction

endpackage

`default_nettype wire

// File: hdl/mf3_if.sv
// Valid/ready channel interfaces: pixel requests, median results, register writes.
// Depends on mf3_pkg.
`default_nettype none

interface mf3_req_if;
   import mf3_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface mf3_rsp_if;
   import mf3_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_med;
   logic [CHAN_W-1:0] green_med;
   logic [CHAN_W-1:0] blue_med;
   logic [CCOL_W-1:0] centre_col;
   logic [CROW_W-1:0] centre_row;
   logic              frame_end;
   modport source (output valid, red_med, green_med, blue_med, centre_col, centre_row,
                   frame_end, input ready);
   modport sink   (input valid, red_med, green_med, blue_med, centre_col, centre_row,
                   frame_end, output ready);
endinterface

interface mf3_csr_if;
   import mf3_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/mf3_line_buf.sv
// Two line stores packed in one memory entry per column: previous row and the row before.
// Depends on mf3_pkg.
`default_nettype none

module mf3_line_buf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  mf3_pkg::line_type            wr_data,
   output mf3_pkg::line_type            rd_data
);
   import mf3_pkg::*;

   line_type mem [MAX_WIDTH];
   line_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// File: hdl/mf3_col_cell.sv
// One window column cell: holds a sorted column and hands it to its left neighbor.
// Depends on mf3_pkg.
`default_nettype none

module mf3_col_cell (
   input  logic             clock,
   input  logic             shift,
   input  mf3_pkg::col_type col_in,
   output mf3_pkg::col_type col_out
);
   import mf3_pkg::*;

   col_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

// File: hdl/mf3_select.sv
// Median selection over three sorted columns: registered partials, then final median of three.
// Depends on mf3_pkg.
`default_nettype none

module mf3_select (
   input  logic             clock,
   input  mf3_pkg::col_type col_left,
   input  mf3_pkg::col_type col_centre,
   input  mf3_pkg::col_type col_right,
   output mf3_pkg::pix_type median
);
   import mf3_pkg::*;

   col_type part_ff;
   col_type part_in;

   always_comb begin
      part_in.r = reduce3(col_left.r, col_centre.r, col_right.r);
      part_in.g = reduce3(col_left.g, col_centre.g, col_right.g);
      part_in.b = reduce3(col_left.b, col_centre.b, col_right.b);
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   assign median.r = med3(part_ff.r);
   assign median.g = med3(part_ff.g);
   assign median.b = med3(part_ff.b);

endmodule

`default_nettype wire

// File: hdl/mf3_rsp_fifo.sv
// Result queue between the fixed-latency pipeline and the result channel.
// Depends on mf3_pkg.
`default_nettype none

module mf3_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  mf3_pkg::rsp_type             push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output mf3_pkg::rsp_type             out_data,
   output logic [mf3_pkg::QC_W-1:0]     count
);
   import mf3_pkg::*;

   rsp_type            slot_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0] wr_ptr_ff;
   logic [RSPQ_AW-1:0] rd_ptr_ff;
   logic [QC_W-1:0]    cnt_ff;
   logic [QC_W-1:0]    cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QC_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSPQ_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSPQ_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

`default_nettype wire

// File: hdl/median_filter_3x3_rgb.sv
// Top level of the streaming 3x3 RGB median filter: counters, line stores, column cells.
// Depends on mf3_pkg, mf3_if, mf3_line_buf, mf3_col_cell, mf3_select, mf3_rsp_fifo.
//
//   channel   dir   payload                                           handshake
//   req_bus   in    red_in, green_in, blue_in                         valid/ready
//   rsp_bus   out   red_med, green_med, blue_med, centre_col/row,     valid/ready
//                   frame_end
//   csr_bus   in    index (0 frame_width, 1 frame_height), data       valid/ready
//
// One pixel request per cycle while req_bus.ready is high; a result is offered on rsp_bus after
// its request is accepted and has passed the right column cell, one partial selection stage and
// the result queue write; the line store read happens at the accepting edge.
// Reset is synchronous and needs no clearing pass; line stores hold data only once written.
// req_bus.ready drops when queued plus in-flight results reach the 8-entry result queue.
// csr_bus.ready is always high; a write to frame_width or frame_height restarts the frame at column 0, row 0.
`default_nettype none

module median_filter_3x3_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   mf3_req_if.sink      req_bus,
   mf3_rsp_if.source    rsp_bus,
   mf3_csr_if.sink      csr_bus
);
   import mf3_pkg::*;

   localparam int              AW   = $clog2(MAX_WIDTH);
   localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WIDTH);
   localparam logic [CNT_W-1:0] MIND = CNT_W'(MIN_DIM);

   logic [FW_W-1:0]  fw_ff;
   logic [FH_W-1:0]  fh_ff;
   logic [AW-1:0]    col_ff;
   logic [AW-1:0]    col_in;
   logic [FH_W-1:0]  row_ff;
   logic [FH_W-1:0]  row_in;
   logic [CNT_W-1:0] w_eff;
   logic [CNT_W-1:0] h_eff;
   logic [CNT_W-1:0] fw_ext;
   logic [CNT_W-1:0] fh_ext;
   logic [CNT_W-1:0] col_ext;
   logic [CNT_W-1:0] row_ext;
   logic             last_col;
   logic             last_row;
   logic             csr_wr;
   logic             csr_hit;
   logic             req_acc;

   logic             s1_vld_ff;
   logic             s1_res_ff;
   logic [AW-1:0]    s1_addr_ff;
   pix_type          px_ff;
   meta_type         s1_meta_ff;
   logic             s2_res_ff;
   meta_type         s2_meta_ff;
   logic             s3_res_ff;
   meta_type         s3_meta_ff;

   line_type         rd_line;
   line_type         wr_line;
   col_type          cols [3];
   col_type          new_col;
   pix_type          median;
   rsp_type          push_data;
   rsp_type          q_data;
   logic             q_valid;
   logic             rsp_pop;
   logic [QC_W-1:0]  q_cnt;
   logic [QC_W-1:0]  pending;

   assign csr_wr  = csr_bus.valid & csr_bus.ready;
   assign req_acc = req_bus.valid & req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      unique case (csr_bus.index)
         REG_FRAME_WIDTH:  csr_hit = 1'b1;
         REG_FRAME_HEIGHT: csr_hit = 1'b1;
         default:          csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
      end else if (csr_wr) begin
         unique case (csr_bus.index)
            REG_FRAME_WIDTH:  fw_ff <= csr_bus.data[FW_W-1:0];
            REG_FRAME_HEIGHT: fh_ff <= csr_bus.data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   assign fw_ext  = CNT_W'(fw_ff);
   assign fh_ext  = CNT_W'(fh_ff);
   assign w_eff   = (fw_ext < MIND) ? MIND : ((fw_ext > MAXW) ? MAXW : fw_ext);
   assign h_eff   = (fh_ext < MIND) ? MIND : fh_ext;
   assign col_ext = CNT_W'(col_ff);
   assign row_ext = CNT_W'(row_ff);
   assign last_col = (col_ext + CNT_W'(1)) >= w_eff;
   assign last_row = (row_ext + CNT_W'(1)) >= h_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr && csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : (row_ff + FH_W'(1));
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s1_res_ff <= 1'b0;
         s2_res_ff <= 1'b0;
         s3_res_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= req_acc;
         s1_res_ff <= req_acc && (col_ff >= AW'(2)) && (row_ff >= FH_W'(2));
         s2_res_ff <= s1_vld_ff & s1_res_ff;
         s3_res_ff <= s2_res_ff;
      end
   end

   // hold request payload and window position alongside the line store read
   always_ff @(posedge clock) begin
      if (req_acc) begin
         px_ff.r               <= req_bus.red_in;
         px_ff.g               <= req_bus.green_in;
         px_ff.b               <= req_bus.blue_in;
         s1_addr_ff            <= col_ff;
         s1_meta_ff.centre_col <= CCOL_W'(col_ff - AW'(1));
         s1_meta_ff.centre_row <= CROW_W'(row_ff - FH_W'(1));
         s1_meta_ff.frame_end  <= last_col & last_row;
      end
      s2_meta_ff <= s1_meta_ff;
      s3_meta_ff <= s2_meta_ff;
   end

   assign wr_line.mid = px_ff;
   assign wr_line.top = rd_line.mid;

   mf3_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_line),
      .rd_data (rd_line)
   );

   assign new_col = sort_col(rd_line.top, rd_line.mid, px_ff);

   mf3_col_cell u_cell_right (
      .clock   (clock),
      .shift   (s1_vld_ff),
      .col_in  (new_col),
      .col_out (cols[2])
   );

   mf3_col_cell u_cell_centre (
      .clock   (clock),
      .shift   (s1_vld_ff),
      .col_in  (cols[2]),
      .col_out (cols[1])
   );

   mf3_col_cell u_cell_left (
      .clock   (clock),
      .shift   (s1_vld_ff),
      .col_in  (cols[1]),
      .col_out (cols[0])
   );

   mf3_select u_select (
      .clock      (clock),
      .col_left   (cols[0]),
      .col_centre (cols[1]),
      .col_right  (cols[2]),
      .median     (median)
   );

   assign push_data.med  = median;
   assign push_data.meta = s3_meta_ff;
   assign rsp_pop        = rsp_bus.valid & rsp_bus.ready;

   mf3_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_res_ff),
      .push_data (push_data),
      .pop       (rsp_pop),
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_cnt)
   );

   // reserve a queue slot for every result still in the pipeline
   assign pending = QC_W'(s1_vld_ff & s1_res_ff) + QC_W'(s2_res_ff) + QC_W'(s3_res_ff);
   assign req_bus.ready = (q_cnt + pending) < QC_W'(RSPQ_DEPTH);

   assign rsp_bus.valid      = q_valid;
   assign rsp_bus.red_med    = q_data.med.r;
   assign rsp_bus.green_med  = q_data.med.g;
   assign rsp_bus.blue_med   = q_data.med.b;
   assign rsp_bus.centre_col = q_data.meta.centre_col;
   assign rsp_bus.centre_row = q_data.meta.centre_row;
   assign rsp_bus.frame_end  = q_data.meta.frame_end;

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s3_res_ff |-> (q_cnt < QC_W'(RSPQ_DEPTH)))
      else $error("result queue full on push");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ext < w_eff)
      else $error("column count beyond frame width");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last_col && !csr_wr) |=> (col_ff == '0))
      else $error("column count did not wrap at end of row");

   a_res_latency: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_res_ff) |-> ##2 s3_res_ff)
      else $error("result lost between window and queue");

endmodule

`default_nettype wire
